// ===== rtl/ydr_pkg.sv =====
// ----------------------------------------------------------------------------
// ydr_pkg
// Shared types, constants and state codes of the yaw damper rate loop.
// ----------------------------------------------------------------------------
package ydr_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPER_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AIRSPEED = 1'd1;

  localparam logic [15:0] GAIN_RESET   = 16'd2048;
  localparam logic [15:0] MINSPD_RESET = 16'd1280;

  localparam int JOB_FIFO_DEPTH = 2;

  // bank limit and angle fold, Q2.13 and Q16 radians
  localparam logic signed [15:0] HALF_PI_Q13  = 16'sd12867;
  localparam logic signed [15:0] BANK_LIM_Q13 = 16'sd11438;
  localparam logic signed [19:0] PI_Q16       = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;

  // series coefficients as reciprocals, exact floor for 18-bit inputs
  localparam logic [31:0] RECIP_42 = 32'd399458;
  localparam logic [31:0] RECIP_20 = 32'd838861;
  localparam logic [31:0] RECIP_6  = 32'd2796203;
  localparam logic [16:0] Q16_ONE  = 17'd65536;

  localparam logic [31:0] GRAV_Q16    = 32'd642679;
  localparam logic [31:0] RAD2DEG_Q16 = 32'd3754936;
  localparam logic [31:0] POLE_Q30    = 32'd1069455447;
  localparam logic [13:0] DEFL_LIMIT  = 14'd11520;

  localparam int DIV_BITS = 25;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic [15:0]        air_speed;
    logic signed [15:0] yaw_rate;
    logic [15:0]        speed_scale;
  } ydr_in_t;

  typedef struct packed {
    logic signed [14:0] servo_deflection;
    logic               saturated;
  } ydr_out_t;

  typedef struct packed {
    logic [15:0] damper_gain;
    logic [15:0] min_airspeed;
  } ydr_cfg_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [16:0]        mag;
    logic               neg;
    logic [15:0]        spd;
    logic signed [15:0] yaw;
    logic [15:0]        scale;
  } ydr_job_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X2,
    ST_D42,
    ST_T1,
    ST_D20,
    ST_T2,
    ST_D6,
    ST_SIN,
    ST_NUM,
    ST_DIV,
    ST_DEG,
    ST_POLE,
    ST_FILT,
    ST_S2,
    ST_K,
    ST_P0,
    ST_P1,
    ST_RES
  } ydr_state_t;

endpackage

// ===== rtl/ydr_front.sv =====
// ----------------------------------------------------------------------------
// ydr_front
// Bank limit, angle fold into +/- pi/2 and airspeed floor for one tick.
// ----------------------------------------------------------------------------
module ydr_front (
  input  ydr_pkg::ydr_in_t  in_word,
  input  ydr_pkg::ydr_cfg_t cfg,
  output ydr_pkg::ydr_job_t job
);

  logic signed [15:0] bank;
  logic signed [19:0] ang;
  logic signed [19:0] fold;
  logic [15:0]        vmin;

  always_comb begin
    bank = in_word.roll_angle;
    if (bank >= -ydr_pkg::HALF_PI_Q13 && bank <= ydr_pkg::HALF_PI_Q13) begin
      if (bank > ydr_pkg::BANK_LIM_Q13) bank = ydr_pkg::BANK_LIM_Q13;
      if (bank < -ydr_pkg::BANK_LIM_Q13) bank = -ydr_pkg::BANK_LIM_Q13;
    end
    ang = {{1{bank[15]}}, bank, 3'b000};
    if (ang > ydr_pkg::HALF_PI_Q16) begin
      fold = ydr_pkg::PI_Q16 - ang;
    end else if (ang < -ydr_pkg::HALF_PI_Q16) begin
      fold = -ydr_pkg::PI_Q16 - ang;
    end else begin
      fold = ang;
    end
    vmin = (cfg.min_airspeed == 16'd0) ? 16'd1 : cfg.min_airspeed;
    job.neg   = fold[19];
    job.mag   = fold[19] ? 17'(-fold) : 17'(fold);
    job.spd   = (in_word.air_speed > vmin) ? in_word.air_speed : vmin;
    job.yaw   = in_word.yaw_rate;
    job.scale = in_word.speed_scale;
  end

endmodule

// ===== rtl/ydr_fifo.sv =====
// ----------------------------------------------------------------------------
// ydr_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module ydr_fifo #(
  parameter int DEPTH = ydr_pkg::JOB_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ydr_pkg::ydr_job_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output ydr_pkg::ydr_job_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ydr_pkg::ydr_job_t mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

endmodule

// ===== rtl/ydr_back.sv =====
// ----------------------------------------------------------------------------
// ydr_back
// Sequencer around one shared multiplier: sine series, turn-rate division,
// high-pass filter and output scaling, with the result register.
// ----------------------------------------------------------------------------
module ydr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  ydr_pkg::ydr_job_t job,
  output logic              job_pop,
  input  ydr_pkg::ydr_cfg_t cfg,
  input  logic              out_pop,
  output logic              out_empty,
  output ydr_pkg::ydr_out_t out_word
);

  localparam logic signed [64:0] MAX32 = 65'sd2147483647;
  localparam logic signed [64:0] MIN32 = -65'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = 32'sh7FFFFFFF;
    else if (v < MIN32) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  ydr_pkg::ydr_state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  ydr_pkg::ydr_out_t  out_r, out_nxt;
  logic signed [31:0] prev_in_r, prev_in_nxt, prev_out_r, prev_out_nxt;

  logic [16:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        spd_r, spd_nxt;
  logic signed [15:0] yaw_r, yaw_nxt;
  logic [15:0]        scale_r, scale_nxt;
  logic [17:0]        x2_r, x2_nxt, y_r, y_nxt;
  logic [16:0]        t_r, t_nxt, sinm_r, sinm_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [ydr_pkg::DIV_BITS-1:0] quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [31:0] hp_in_r, hp_in_nxt;
  logic signed [32:0] pole_r, pole_nxt;
  logic [31:0]        m_r, m_nxt, s2_r, s2_nxt;
  logic               pos_r, pos_nxt;
  logic [47:0]        k_r, k_nxt;
  logic [80:0]        acc_r, acc_nxt;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [25:0] offs;
  logic signed [26:0] diff;
  logic [16:0]        trial;
  logic [37:0]        dsum;
  logic signed [64:0] fsum;
  logic signed [31:0] hp;
  logic [80:0]        rsum;
  logic [36:0]        rmag;
  logic               rsat;
  logic [13:0]        mg;

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    offs = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    diff = 27'(yaw_r) - 27'(offs);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ydr_pkg::ST_X2:   begin mul_a = 33'(mag_r);  mul_b = 32'(mag_r); end
      ydr_pkg::ST_D42:  begin mul_a = 33'(x2_r);   mul_b = ydr_pkg::RECIP_42; end
      ydr_pkg::ST_T1:   begin mul_a = 33'(x2_r);   mul_b = 32'(t_r); end
      ydr_pkg::ST_D20:  begin mul_a = 33'(y_r);    mul_b = ydr_pkg::RECIP_20; end
      ydr_pkg::ST_T2:   begin mul_a = 33'(x2_r);   mul_b = 32'(t_r); end
      ydr_pkg::ST_D6:   begin mul_a = 33'(y_r);    mul_b = ydr_pkg::RECIP_6; end
      ydr_pkg::ST_SIN:  begin mul_a = 33'(mag_r);  mul_b = 32'(t_r); end
      ydr_pkg::ST_NUM:  begin mul_a = 33'(sinm_r); mul_b = ydr_pkg::GRAV_Q16; end
      ydr_pkg::ST_DEG:  begin mul_a = 33'(diff);   mul_b = ydr_pkg::RAD2DEG_Q16; end
      ydr_pkg::ST_POLE: begin mul_a = 33'(prev_out_r); mul_b = ydr_pkg::POLE_Q30; end
      ydr_pkg::ST_S2:   begin mul_a = 33'(scale_r); mul_b = 32'(scale_r); end
      ydr_pkg::ST_K:    begin mul_a = 33'(s2_r);   mul_b = 32'(cfg.damper_gain); end
      ydr_pkg::ST_P0:   begin mul_a = 33'(m_r);    mul_b = 32'(k_r[23:0]); end
      ydr_pkg::ST_P1:   begin mul_a = 33'(m_r);    mul_b = 32'(k_r[47:24]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    prev_in_nxt   = prev_in_r;
    prev_out_nxt  = prev_out_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    spd_nxt   = spd_r;
    yaw_nxt   = yaw_r;
    scale_nxt = scale_r;
    x2_nxt    = x2_r;
    y_nxt     = y_r;
    t_nxt     = t_r;
    sinm_nxt  = sinm_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    hp_in_nxt = hp_in_r;
    pole_nxt  = pole_r;
    m_nxt     = m_r;
    pos_nxt   = pos_r;
    s2_nxt    = s2_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    job_pop   = 1'b0;
    trial = {rem_r, quo_r[ydr_pkg::DIV_BITS-1]};
    dsum  = 38'(prod[36:0]) + 38'({spd_r, 11'b0});
    fsum  = 65'(pole_r) + 65'(hp_in_r) - 65'(prev_in_r);
    hp    = sat32(fsum);
    rsum  = acc_r + (81'(1) << 43);
    rmag  = rsum[80:44];
    rsat  = rmag > 37'(ydr_pkg::DEFL_LIMIT);
    mg    = rsat ? ydr_pkg::DEFL_LIMIT : rmag[13:0];

    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;

    case (state_r)
      ydr_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          mag_nxt   = job.mag;
          neg_nxt   = job.neg;
          spd_nxt   = job.spd;
          yaw_nxt   = job.yaw;
          scale_nxt = job.scale;
          state_nxt = ydr_pkg::ST_X2;
        end
      end
      ydr_pkg::ST_X2: begin
        x2_nxt    = prod[33:16];
        state_nxt = ydr_pkg::ST_D42;
      end
      ydr_pkg::ST_D42: begin
        t_nxt     = ydr_pkg::Q16_ONE - 17'(prod[42:24]);
        state_nxt = ydr_pkg::ST_T1;
      end
      ydr_pkg::ST_T1: begin
        y_nxt     = prod[33:16];
        state_nxt = ydr_pkg::ST_D20;
      end
      ydr_pkg::ST_D20: begin
        t_nxt     = ydr_pkg::Q16_ONE - 17'(prod[42:24]);
        state_nxt = ydr_pkg::ST_T2;
      end
      ydr_pkg::ST_T2: begin
        y_nxt     = prod[33:16];
        state_nxt = ydr_pkg::ST_D6;
      end
      ydr_pkg::ST_D6: begin
        t_nxt     = ydr_pkg::Q16_ONE - 17'(prod[42:24]);
        state_nxt = ydr_pkg::ST_SIN;
      end
      ydr_pkg::ST_SIN: begin
        sinm_nxt  = prod[32:16];
        state_nxt = ydr_pkg::ST_NUM;
      end
      ydr_pkg::ST_NUM: begin
        // den is v * 4096, so divide the shifted dividend by v alone
        quo_nxt   = dsum[36:12];
        rem_nxt   = '0;
        cnt_nxt   = 5'(ydr_pkg::DIV_BITS - 1);
        state_nxt = ydr_pkg::ST_DIV;
      end
      ydr_pkg::ST_DIV: begin
        if (trial >= {1'b0, spd_r}) begin
          rem_nxt = 16'(trial - {1'b0, spd_r});
          quo_nxt = {quo_r[ydr_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial[15:0];
          quo_nxt = {quo_r[ydr_pkg::DIV_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = ydr_pkg::ST_DEG;
      end
      ydr_pkg::ST_DEG: begin
        hp_in_nxt = sat32((prod + 65'sd2048) >>> 12);
        state_nxt = ydr_pkg::ST_POLE;
      end
      ydr_pkg::ST_POLE: begin
        pole_nxt  = 33'((prod + 65'sd536870912) >>> 30);
        state_nxt = ydr_pkg::ST_FILT;
      end
      ydr_pkg::ST_FILT: begin
        prev_in_nxt  = hp_in_r;
        prev_out_nxt = hp;
        m_nxt        = hp[31] ? 32'(-hp) : 32'(hp);
        pos_nxt      = !hp[31] && (hp != 32'sd0);
        state_nxt    = ydr_pkg::ST_S2;
      end
      ydr_pkg::ST_S2: begin
        s2_nxt    = prod[31:0];
        state_nxt = ydr_pkg::ST_K;
      end
      ydr_pkg::ST_K: begin
        k_nxt     = prod[47:0];
        state_nxt = ydr_pkg::ST_P0;
      end
      ydr_pkg::ST_P0: begin
        acc_nxt   = 81'(prod[55:0]);
        state_nxt = ydr_pkg::ST_P1;
      end
      ydr_pkg::ST_P1: begin
        acc_nxt   = acc_r + 81'({prod[55:0], 24'b0});
        state_nxt = ydr_pkg::ST_RES;
      end
      ydr_pkg::ST_RES: begin
        // hold here while the previous word still waits
        if (!out_valid_r || out_pop) begin
          out_nxt.servo_deflection = pos_r ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
          out_nxt.saturated        = rsat;
          out_valid_nxt            = 1'b1;
          state_nxt                = ydr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ydr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ydr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_in_r   <= prev_in_nxt;
      prev_out_r  <= prev_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    spd_r   <= spd_nxt;
    yaw_r   <= yaw_nxt;
    scale_r <= scale_nxt;
    x2_r    <= x2_nxt;
    y_r     <= y_nxt;
    t_r     <= t_nxt;
    sinm_r  <= sinm_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    hp_in_r <= hp_in_nxt;
    pole_r  <= pole_nxt;
    m_r     <= m_nxt;
    pos_r   <= pos_nxt;
    s2_r    <= s2_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
  end

endmodule

// ===== rtl/yaw_damper_rate_loop.sv =====
// ----------------------------------------------------------------------------
// yaw_damper_rate_loop
// Coordinated-turn yaw damper: one rudder word per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_word (roll, airspeed, yaw rate, speed scaler) is taken on push when
//   full is low; it lands in a two-word job queue after bank limiting and
//   angle folding.
//   out_word holds the oldest rudder word while out_empty is low; pop takes
//   it. One word comes out per word in, in order.
//   Each tick in the back end takes the job from the queue, then passes
//   through 14 steps on one shared 33x32 multiplier, a 25-bit
//   one-bit-per-cycle turn-rate divider, the filter update and the result
//   hand-off. The back end takes the next job only once the last word has
//   gone to the result register; the queue takes new words meanwhile.
//   If the receiver stalls, one finished word waits in the result register,
//   the back end holds its next result, and the queue fills before full
//   rises.
//   cfg_we writes damper_gain (index 0) or min_airspeed (index 1) at once;
//   write only while the block is idle.
//   Reset clears the filter history and the queue, empties the result
//   register and restores the register defaults (gain 0.5, min airspeed 5 m/s).
// ----------------------------------------------------------------------------
module yaw_damper_rate_loop #(
  parameter int JOB_DEPTH = ydr_pkg::JOB_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  ydr_pkg::ydr_in_t              in_word,
  output logic                          out_empty,
  input  logic                          out_pop,
  output ydr_pkg::ydr_out_t             out_word,
  input  logic                          cfg_we,
  input  logic [ydr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  ydr_pkg::ydr_cfg_t cfg_r, cfg_nxt;
  ydr_pkg::ydr_job_t job_in, job_out;
  logic              job_empty, job_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ydr_pkg::CFG_DAMPER_GAIN:  cfg_nxt.damper_gain  = cfg_wdata;
        ydr_pkg::CFG_MIN_AIRSPEED: cfg_nxt.min_airspeed = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.damper_gain  <= ydr_pkg::GAIN_RESET;
      cfg_r.min_airspeed <= ydr_pkg::MINSPD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ydr_front u_front (
    .in_word (in_word),
    .cfg     (cfg_r),
    .job     (job_in)
  );

  ydr_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_out)
  );

  ydr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .cfg       (cfg_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

endmodule
